@@ rtl/awmp_pkg.sv @@
`timescale 1ns / 1ps
package awmp_pkg;

  localparam int PRICE_W = 32;
  localparam int WIN_W   = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_WINDOW = 1'd1;

  localparam logic [WIN_W-1:0] MIN_WINDOW_RST = 5'd2;
  localparam logic [WIN_W-1:0] MAX_WINDOW_RST = 5'd20;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               last;
  } awmp_in_t;

  typedef struct packed {
    logic [WIN_W-1:0] best_window;
    logic             prediction;
  } awmp_out_t;

  typedef struct packed {
    logic push;
    logic score;
    logic rise;
    logic clear;
  } awmp_ctl_t;

endpackage

@@ rtl/awmp_cell.sv @@
`timescale 1ns / 1ps
module awmp_cell #(
  parameter int DW = 6,
  parameter int CW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  awmp_pkg::awmp_ctl_t   ctl,
  input  logic                  h_in,
  input  logic                  v_in,
  output logic                  h_out,
  output logic                  v_out,
  output logic signed [DW-1:0]  d_out,
  output logic [CW-1:0]         cnt_out
);
  import awmp_pkg::*;

  localparam logic signed [DW-1:0] P_ONE = DW'(1);
  localparam logic signed [DW-1:0] M_ONE = DW'(-1);
  localparam logic signed [DW-1:0] ZERO  = DW'(0);

  logic                 h_r, h_nxt;
  logic                 v_r, v_nxt;
  logic signed [DW-1:0] d_r, d_nxt;
  logic [CW-1:0]        cnt_r, cnt_nxt;
  logic signed [DW-1:0] add_in, sub_out;
  logic                 hit;

  // d_r is ones minus zeros over this cell's window, clipped to the history
  always_comb begin
    add_in  = ctl.rise ? P_ONE : M_ONE;
    sub_out = v_r ? (h_r ? P_ONE : M_ONE) : ZERO;
    hit     = ctl.rise ? (d_r > ZERO) : (d_r < ZERO);
    h_nxt   = h_r;
    v_nxt   = v_r;
    d_nxt   = d_r;
    cnt_nxt = cnt_r;
    if (ctl.clear) begin
      h_nxt   = 1'b0;
      v_nxt   = 1'b0;
      d_nxt   = ZERO;
      cnt_nxt = '0;
    end else if (ctl.push) begin
      h_nxt = h_in;
      v_nxt = v_in;
      d_nxt = d_r + add_in - sub_out;
      if (ctl.score && hit && (cnt_r != '1)) begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r   <= 1'b0;
      v_r   <= 1'b0;
      d_r   <= ZERO;
      cnt_r <= '0;
    end else begin
      h_r   <= h_nxt;
      v_r   <= v_nxt;
      d_r   <= d_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign h_out   = h_r;
  assign v_out   = v_r;
  assign d_out   = d_r;
  assign cnt_out = cnt_r;

endmodule

@@ rtl/adaptive_window_majority_predictor.sv @@
`timescale 1ns / 1ps
// Predicts the direction of the next price from a series of daily prices. While a series
// runs, one price beat is taken per clock: a row of MAX_WINDOW cells, one per window length,
// shifts the rise history along and scores every window in that same cycle. After the beat
// flagged last, input is held off while a scanner walks the counters of windows lo to hi
// (min_window raised to 1 and max_window capped at MAX_WINDOW), one per cycle. The block is
// busy until the scan has passed hi, and then until the result is loaded and the series is
// cleared, which waits until the previous result has been taken. Configuration may be
// written only between series.
module adaptive_window_majority_predictor #(
  parameter int MAX_WINDOW  = 20,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  awmp_pkg::awmp_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output awmp_pkg::awmp_out_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [awmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [awmp_pkg::WIN_W-1:0]          cfg_data
);
  import awmp_pkg::*;

  localparam int DW  = $clog2(MAX_WINDOW + 1) + 1;
  localparam int CIW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int IW  = ($clog2(MAX_WINDOW + 2) > WIN_W) ? $clog2(MAX_WINDOW + 2) : WIN_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } st_t;

  st_t                  st_r, st_nxt;
  logic [WIN_W-1:0]     min_window_r, max_window_r;
  logic [PRICE_W-1:0]   prev_price_r, prev_price_nxt;
  logic                 started_r, started_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        best_r, best_nxt;
  logic [COUNT_WIDTH-1:0] best_cnt_r, best_cnt_nxt;
  logic signed [DW-1:0] best_d_r, best_d_nxt;
  logic                 out_valid_r, out_valid_nxt;
  awmp_out_t            out_data_r, out_data_nxt;

  logic                 in_fire, cfg_fire, out_load;
  logic [IW-1:0]        lo, hi, idx_m1;
  logic [CIW-1:0]       sel;
  awmp_ctl_t            ctl;

  logic                   h_w   [MAX_WINDOW+1];
  logic                   v_w   [MAX_WINDOW+1];
  logic signed [DW-1:0]   d_w   [MAX_WINDOW];
  logic [COUNT_WIDTH-1:0] cnt_w [MAX_WINDOW];

  assign in_ready  = (st_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (st_r == ST_DONE) && (!out_valid_r || out_ready);

  assign lo = (min_window_r == '0) ? IW'(1) : IW'(min_window_r);
  assign hi = (IW'(max_window_r) > IW'(MAX_WINDOW)) ? IW'(MAX_WINDOW) : IW'(max_window_r);
  assign idx_m1 = idx_r - IW'(1);
  assign sel    = idx_m1[CIW-1:0];

  always_comb begin
    ctl.push  = in_fire;
    ctl.score = in_fire && started_r;
    ctl.rise  = started_r && (in_data.price > prev_price_r);
    ctl.clear = out_load;
  end

  // rise bits enter at window one and move toward the longest window
  assign h_w[0] = ctl.rise;
  assign v_w[0] = 1'b1;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    awmp_cell #(
      .DW (DW),
      .CW (COUNT_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .h_in    (h_w[i]),
      .v_in    (v_w[i]),
      .h_out   (h_w[i+1]),
      .v_out   (v_w[i+1]),
      .d_out   (d_w[i]),
      .cnt_out (cnt_w[i])
    );
  end

  always_comb begin
    st_nxt         = st_r;
    prev_price_nxt = prev_price_r;
    started_nxt    = started_r;
    idx_nxt        = idx_r;
    best_nxt       = best_r;
    best_cnt_nxt   = best_cnt_r;
    best_d_nxt     = best_d_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (st_r)
      ST_IDLE: begin
        if (in_fire) begin
          prev_price_nxt = in_data.price;
          started_nxt    = 1'b1;
          if (in_data.last) begin
            st_nxt       = ST_SCAN;
            idx_nxt      = lo;
            best_nxt     = '0;
            best_cnt_nxt = '0;
            best_d_nxt   = '0;
          end
        end
      end
      ST_SCAN: begin
        if (idx_r > hi) begin
          st_nxt = ST_DONE;
        end else begin
          if (cnt_w[sel] > best_cnt_r) begin
            best_nxt     = idx_r;
            best_cnt_nxt = cnt_w[sel];
            best_d_nxt   = d_w[sel];
          end
          idx_nxt = idx_r + IW'(1);
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.best_window = best_r[WIN_W-1:0];
          out_data_nxt.prediction  = !best_d_r[DW-1];
          started_nxt              = 1'b0;
          prev_price_nxt           = '0;
          st_nxt                   = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      min_window_r <= MIN_WINDOW_RST;
      max_window_r <= MAX_WINDOW_RST;
      prev_price_r <= '0;
      started_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      prev_price_r <= prev_price_nxt;
      started_r    <= started_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_fire) begin
        unique case (cfg_index)
          CFG_MIN_WINDOW: min_window_r <= cfg_data;
          CFG_MAX_WINDOW: max_window_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    best_r     <= best_nxt;
    best_cnt_r <= best_cnt_nxt;
    best_d_r   <= best_d_nxt;
    out_data_r <= out_data_nxt;
  end

  a_last_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_data.last |=> st_r == ST_SCAN)
    else $error("last beat did not start the counter scan");

  a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_SCAN) && (best_r != '0) |-> (best_r >= lo) && (best_r <= hi))
    else $error("chosen window outside the configured range");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r) == ST_DONE)
    else $error("result loaded outside the done state");

  a_series_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> !started_r && (st_r == ST_IDLE))
    else $error("series not cleared after the result");

endmodule
